// ===== sv/image_buffer_raster_ops_defines.svh =====
// assertion macros for the image buffer raster block
`ifndef IMAGE_BUFFER_RASTER_OPS_DEFINES_SVH
`define IMAGE_BUFFER_RASTER_OPS_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IBRO_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IBRO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IBRO_ASSERT_SAME(lbl, ante, cons)
`define IBRO_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/ibro_pkg.sv =====
// shared types and constants for the image buffer raster block
package ibro_pkg;

  localparam int unsigned MAX_DIM_DEF    = 64;
  localparam int unsigned PIXEL_BITS_DEF = 16;

  typedef enum logic [2:0] {
    ACT_NEW    = 3'd0,
    ACT_POINT  = 3'd1,
    ACT_RECT   = 3'd2,
    ACT_THRESH = 3'd3,
    ACT_FLIP   = 3'd4,
    ACT_ROTATE = 3'd5,
    ACT_READ   = 3'd6
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_POINT,
    ST_READ,
    ST_FLIP_RA,
    ST_FLIP_RB,
    ST_FLIP_WA,
    ST_FLIP_WB,
    ST_DONE
  } state_e;

endpackage

// ===== sv/ibro_mem.sv =====
// pixel memory, one write port and one registered read port
module ibro_mem #(
  parameter int unsigned AddrBits = 13,
  parameter int unsigned DataBits = 16
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [DataBits-1:0] wdata_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [DataBits-1:0] rdata_o
);

  logic [DataBits-1:0] mem [2**AddrBits];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/image_buffer_raster_ops.sv =====
// image buffer with raster actions, top level
// point, read: via the point or read state to done; next start is taken the cycle after done
// new image, rectangle, threshold, rotate: scan one pixel per cycle, then drain, then done
// flip: per pixel pair read A, read B, write A, write B, set by the single read and write port
// nothing to scan or write: straight to done; results are strobed once on done_o and cannot be stalled
// reset clears size and bank select; pixel memory holds garbage until written
`include "image_buffer_raster_ops_defines.svh"
module image_buffer_raster_ops import ibro_pkg::*; #(
  parameter int unsigned MaxDim    = MAX_DIM_DEF,
  parameter int unsigned PixelBits = PIXEL_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         action_i,
  input  logic signed [11:0] pos_x_i,
  input  logic signed [11:0] pos_y_i,
  input  logic [11:0]        span_x_i,
  input  logic [11:0]        span_y_i,
  input  logic signed [15:0] pixel_value_i,
  output logic               done_o,
  output logic signed [15:0] read_value_o,
  output logic               out_of_range_o,
  output logic [6:0]         image_width_o,
  output logic [6:0]         image_height_o
);

  localparam int unsigned IW = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int unsigned DW = $clog2(MaxDim + 1);
  localparam int unsigned AW = 2 * IW + 1;

  state_e state_q, state_d;
  logic   bank_q, bank_d;
  logic [DW-1:0] cur_w_q, cur_w_d, cur_h_q, cur_h_d;
  logic [IW-1:0] x_q, x_d, y_q, y_d;
  logic          p_valid_q;
  logic [IW-1:0] p_x_q, p_y_q;
  action_e       act_q;
  logic signed [11:0] pos_x_q, pos_y_q;
  logic [11:0]        span_x_q, span_y_q;
  logic signed [15:0] val_q;
  logic               oor_q;
  logic signed [PixelBits-1:0] tmp_q;

  logic                        accept;
  action_e                     act_in;
  logic                        in_img;
  logic [DW-1:0]               new_w, new_h, half_w;
  logic                        last_scan, last_flip;
  logic [IW-1:0]               col_b, col_r;
  logic                        outline;
  logic signed [13:0]          jx, iy, x0, y0, x1, y1;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic signed [PixelBits-1:0] mem_wdata, rdata;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);
  assign act_in = action_e'(action_i);
  assign in_img = !pos_x_i[11] && ($unsigned(pos_x_i) < 12'(cur_w_q)) &&
                  !pos_y_i[11] && ($unsigned(pos_y_i) < 12'(cur_h_q));
  assign new_w  = (span_x_i > 12'(MaxDim)) ? DW'(MaxDim) : DW'(span_x_i);
  assign new_h  = (span_y_i > 12'(MaxDim)) ? DW'(MaxDim) : DW'(span_y_i);
  assign half_w = cur_w_q >> 1;

  assign last_scan = (DW'(x_q) + DW'(1) == cur_w_q) && (DW'(y_q) + DW'(1) == cur_h_q);
  assign last_flip = (DW'(x_q) + DW'(1) == half_w) && (DW'(y_q) + DW'(1) == cur_h_q);
  assign col_b     = IW'(cur_w_q - DW'(1) - DW'(x_q));
  assign col_r     = IW'(cur_h_q - DW'(1) - DW'(p_y_q));

  // outline test for the rectangle
  assign jx = $signed(14'(p_x_q));
  assign iy = $signed(14'(p_y_q));
  assign x0 = 14'(pos_x_q);
  assign y0 = 14'(pos_y_q);
  assign x1 = x0 + $signed({2'b00, span_x_q});
  assign y1 = y0 + $signed({2'b00, span_y_q});
  assign outline = (x0 <= jx) && (jx < x1) && (y0 <= iy) && (iy < y1) &&
                   !((x0 < jx) && (jx < x1 - 14'sd1) && (y0 < iy) && (iy < y1 - 14'sd1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (act_in)
            ACT_NEW:    state_d = (new_w == '0 || new_h == '0) ? ST_DONE : ST_SCAN;
            ACT_POINT:  state_d = in_img ? ST_POINT : ST_DONE;
            ACT_RECT,
            ACT_THRESH,
            ACT_ROTATE: state_d = (cur_w_q == '0 || cur_h_q == '0) ? ST_DONE : ST_SCAN;
            ACT_FLIP:   state_d = (half_w == '0 || cur_h_q == '0) ? ST_DONE : ST_FLIP_RA;
            ACT_READ:   state_d = in_img ? ST_READ : ST_DONE;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN:    state_d = last_scan ? ST_DRAIN : ST_SCAN;
      ST_DRAIN:   state_d = ST_DONE;
      ST_POINT:   state_d = ST_DONE;
      ST_READ:    state_d = ST_DONE;
      ST_FLIP_RA: state_d = ST_FLIP_RB;
      ST_FLIP_RB: state_d = ST_FLIP_WA;
      ST_FLIP_WA: state_d = ST_FLIP_WB;
      ST_FLIP_WB: state_d = last_flip ? ST_DONE : ST_FLIP_RA;
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // size, bank and scan counters
  always_comb begin
    cur_w_d = cur_w_q;
    cur_h_d = cur_h_q;
    bank_d  = bank_q;
    x_d     = x_q;
    y_d     = y_q;
    if (accept) begin
      x_d = '0;
      y_d = '0;
      if (act_in == ACT_NEW) begin
        cur_w_d = new_w;
        cur_h_d = new_h;
      end else if (act_in == ACT_ROTATE && (cur_w_q == '0 || cur_h_q == '0)) begin
        // empty image still swaps its size
        cur_w_d = cur_h_q;
        cur_h_d = cur_w_q;
        bank_d  = !bank_q;
      end
    end else if (state_q == ST_SCAN) begin
      if (DW'(x_q) + DW'(1) == cur_w_q) begin
        x_d = '0;
        y_d = y_q + IW'(1);
      end else begin
        x_d = x_q + IW'(1);
      end
    end else if (state_q == ST_FLIP_WB) begin
      if (DW'(x_q) + DW'(1) == half_w) begin
        x_d = '0;
        y_d = y_q + IW'(1);
      end else begin
        x_d = x_q + IW'(1);
      end
    end else if (state_q == ST_DRAIN && act_q == ACT_ROTATE) begin
      cur_w_d = cur_h_q;
      cur_h_d = cur_w_q;
      bank_d  = !bank_q;
    end
  end

  // memory control and results
  always_comb begin
    mem_raddr = {bank_q, y_q, x_q};
    mem_we    = 1'b0;
    mem_waddr = {bank_q, p_y_q, p_x_q};
    mem_wdata = '0;
    case (state_q)
      ST_FLIP_RB: mem_raddr = {bank_q, y_q, col_b};
      ST_READ:    mem_raddr = {bank_q, pos_y_q[IW-1:0], pos_x_q[IW-1:0]};
      default:    ;
    endcase
    if (p_valid_q) begin
      case (act_q)
        ACT_NEW: mem_we = 1'b1;
        ACT_RECT: begin
          mem_we    = outline;
          mem_wdata = PixelBits'(val_q);
        end
        ACT_THRESH: mem_we = (rdata <= val_q);
        ACT_ROTATE: begin
          mem_we    = 1'b1;
          mem_waddr = {!bank_q, p_x_q, col_r};
          mem_wdata = rdata;
        end
        default: ;
      endcase
    end
    case (state_q)
      ST_POINT: begin
        mem_we    = 1'b1;
        mem_waddr = {bank_q, pos_y_q[IW-1:0], pos_x_q[IW-1:0]};
        mem_wdata = PixelBits'(val_q);
      end
      ST_FLIP_WA: begin
        mem_we    = 1'b1;
        mem_waddr = {bank_q, y_q, x_q};
        mem_wdata = rdata;
      end
      ST_FLIP_WB: begin
        mem_we    = 1'b1;
        mem_waddr = {bank_q, y_q, col_b};
        mem_wdata = tmp_q;
      end
      default: ;
    endcase
    done_o         = (state_q == ST_DONE);
    out_of_range_o = (act_q == ACT_READ) && oor_q;
    read_value_o   = ((act_q == ACT_READ) && !oor_q) ? 16'(rdata) : '0;
    image_width_o  = 7'(cur_w_q);
    image_height_o = 7'(cur_h_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bank_q    <= 1'b0;
      cur_w_q   <= '0;
      cur_h_q   <= '0;
      x_q       <= '0;
      y_q       <= '0;
      p_valid_q <= 1'b0;
      act_q     <= ACT_NEW;
      oor_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      bank_q    <= bank_d;
      cur_w_q   <= cur_w_d;
      cur_h_q   <= cur_h_d;
      x_q       <= x_d;
      y_q       <= y_d;
      p_valid_q <= (state_q == ST_SCAN);
      if (accept) begin
        act_q <= act_in;
        oor_q <= !in_img;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_x_q <= x_q;
    p_y_q <= y_q;
    if (state_q == ST_FLIP_RB) begin
      tmp_q <= rdata;
    end
    if (accept) begin
      pos_x_q  <= pos_x_i;
      pos_y_q  <= pos_y_i;
      span_x_q <= span_x_i;
      span_y_q <= span_y_i;
      val_q    <= pixel_value_i;
    end
  end

  ibro_mem #(
    .AddrBits(AW),
    .DataBits(PixelBits)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(rdata)
  );

  `IBRO_ASSERT_NEXT(a_done_then_idle, done_o, !busy_o)
  `IBRO_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  `IBRO_ASSERT_SAME(a_size_bound, 1'b1, cur_w_q <= DW'(MaxDim) && cur_h_q <= DW'(MaxDim))

endmodule

// ===== tb/image_buffer_raster_ops_test.sv =====
// testbench for the image buffer raster block: self-checking scoreboard with random stimulus
`timescale 1ns / 100ps
module image_buffer_raster_ops_test;
  import ibro_pkg::*;

  localparam int          Dim        = MAX_DIM_DEF;
  localparam logic [2:0]  ACT_UNUSED = 3'd7;
  localparam int          CycleLimit = 4000000;

  typedef struct {
    logic signed [15:0] read_value;
    logic               out_of_range;
    logic [6:0]         image_width;
    logic [6:0]         image_height;
  } raster_result_t;

  class raster_scoreboard;
    logic signed [15:0] pixels [2][Dim*Dim];
    bit                 bank;
    int                 width;
    int                 height;
    raster_result_t     expected_q[$];
    int                 failures;

    function void note_item(logic [2:0] act, logic signed [11:0] px, logic signed [11:0] py,
                            logic [11:0] sx, logic [11:0] sy, logic signed [15:0] val);
      raster_result_t r;
      int x0, y0, x1, y1, i, j;
      logic signed [15:0] t;
      x0 = px;
      y0 = py;
      x1 = x0 + int'(sx);
      y1 = y0 + int'(sy);
      r.read_value   = '0;
      r.out_of_range = 1'b0;
      case (act)
        ACT_NEW: begin
          width  = (sx > Dim) ? Dim : int'(sx);
          height = (sy > Dim) ? Dim : int'(sy);
          for (i = 0; i < Dim*Dim; i++) pixels[bank][i] = '0;
        end
        ACT_POINT: begin
          if (x0 >= 0 && x0 < width && y0 >= 0 && y0 < height) pixels[bank][y0*Dim+x0] = val;
        end
        ACT_RECT: begin
          for (i = 0; i < height; i++)
            for (j = 0; j < width; j++)
              if (x0 <= j && j < x1 && y0 <= i && i < y1 &&
                  !(x0 < j && j < x1 - 1 && y0 < i && i < y1 - 1))
                pixels[bank][i*Dim+j] = val;
        end
        ACT_THRESH: begin
          for (i = 0; i < height; i++)
            for (j = 0; j < width; j++)
              if (pixels[bank][i*Dim+j] <= val) pixels[bank][i*Dim+j] = '0;
        end
        ACT_FLIP: begin
          for (i = 0; i < height; i++)
            for (j = 0; j < width / 2; j++) begin
              t = pixels[bank][i*Dim+j];
              pixels[bank][i*Dim+j] = pixels[bank][i*Dim+width-1-j];
              pixels[bank][i*Dim+width-1-j] = t;
            end
        end
        ACT_ROTATE: begin
          for (i = 0; i < height; i++)
            for (j = 0; j < width; j++)
              pixels[!bank][j*Dim+height-1-i] = pixels[bank][i*Dim+j];
          bank = !bank;
          i = width;
          width = height;
          height = i;
        end
        ACT_READ: begin
          if (x0 >= 0 && x0 < width && y0 >= 0 && y0 < height)
            r.read_value = pixels[bank][y0*Dim+x0];
          else
            r.out_of_range = 1'b1;
        end
        default: ;
      endcase
      r.image_width  = width[6:0];
      r.image_height = height[6:0];
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(raster_result_t got);
      raster_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no item pending");
        failures++;
        return;
      end
      e = expected_q.pop_front();
      if (got.read_value !== e.read_value) begin
        $error("read_value expected %0d actual %0d", e.read_value, got.read_value);
        failures++;
      end
      if (got.out_of_range !== e.out_of_range) begin
        $error("out_of_range expected %0d actual %0d", e.out_of_range, got.out_of_range);
        failures++;
      end
      if (got.image_width !== e.image_width) begin
        $error("image_width expected %0d actual %0d", e.image_width, got.image_width);
        failures++;
      end
      if (got.image_height !== e.image_height) begin
        $error("image_height expected %0d actual %0d", e.image_height, got.image_height);
        failures++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [2:0]         action_i = '0;
  logic signed [11:0] pos_x_i = '0;
  logic signed [11:0] pos_y_i = '0;
  logic [11:0]        span_x_i = '0;
  logic [11:0]        span_y_i = '0;
  logic signed [15:0] pixel_value_i = '0;
  logic               done_o;
  logic signed [15:0] read_value_o;
  logic               out_of_range_o;
  logic [6:0]         image_width_o;
  logic [6:0]         image_height_o;

  raster_scoreboard sb = new();
  int               cycle_count = 0;

  image_buffer_raster_ops u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    raster_result_t got;
    if (rst_ni && done_o) begin
      got.read_value   = read_value_o;
      got.out_of_range = out_of_range_o;
      got.image_width  = image_width_o;
      got.image_height = image_height_o;
      sb.check_result(got);
    end
  end

  // drive one item and wait for it to be taken; start stays high across back-to-back items
  task automatic send_item(logic [2:0] act, logic signed [11:0] px, logic signed [11:0] py,
                           logic [11:0] sx, logic [11:0] sy, logic signed [15:0] val);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4));
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    action_i      <= act;
    pos_x_i       <= px;
    pos_y_i       <= py;
    span_x_i      <= sx;
    span_y_i      <= sy;
    pixel_value_i <= val;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(act, px, py, sx, sy, val);
  endtask

  function automatic logic signed [11:0] pick_pos(int limit);
    if ($urandom_range(0, 4) == 0) return 12'($urandom());
    return 12'($urandom_range(0, limit + 1));
  endfunction

  initial begin
    logic [2:0] act;
    int         n, k;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty image after reset
    send_item(ACT_READ, 12'sd0, 12'sd0, '0, '0, '0);
    send_item(ACT_UNUSED, 12'sd5, 12'sd5, 12'd5, 12'd5, 16'sd9);
    send_item(ACT_FLIP, '0, '0, '0, '0, '0);
    send_item(ACT_ROTATE, '0, '0, '0, '0, '0);
    // full size, saturated
    send_item(ACT_NEW, '0, '0, 12'hfff, 12'hfff, '0);
    send_item(ACT_POINT, 12'sd0, 12'sd0, '0, '0, 16'sh7fff);
    send_item(ACT_POINT, 12'sd63, 12'sd63, '0, '0, 16'sh8000);
    send_item(ACT_POINT, 12'sd64, 12'sd0, '0, '0, 16'sd1);
    send_item(ACT_RECT, 12'sh800, 12'sh800, 12'hfff, 12'hfff, 16'sd77);
    send_item(ACT_RECT, 12'sd10, 12'sd10, 12'd0, 12'd5, 16'sd3);
    send_item(ACT_THRESH, '0, '0, '0, '0, 16'sh8000);
    send_item(ACT_READ, 12'sd63, 12'sd63, '0, '0, '0);
    send_item(ACT_READ, 12'sd2047, -12'sd1, '0, '0, '0);
    // small non-square image
    send_item(ACT_NEW, '0, '0, 12'd5, 12'd3, '0);
    send_item(ACT_RECT, 12'sd1, -12'sd1, 12'd3, 12'd3, -16'sd5);
    send_item(ACT_POINT, 12'sd4, 12'sd2, '0, '0, 16'sd42);
    send_item(ACT_FLIP, '0, '0, '0, '0, '0);
    send_item(ACT_READ, 12'sd0, 12'sd2, '0, '0, '0);
    send_item(ACT_ROTATE, '0, '0, '0, '0, '0);
    send_item(ACT_READ, 12'sd0, 12'sd0, '0, '0, '0);
    send_item(ACT_THRESH, '0, '0, '0, '0, 16'sh7fff);
    send_item(ACT_READ, 12'sd2, 12'sd4, '0, '0, '0);
    send_item(ACT_NEW, '0, '0, 12'd0, 12'd7, '0);

    for (n = 0; n < 117; n++) begin
      k = $urandom_range(0, 19);
      if (k < 2) act = ACT_NEW;
      else if (k < 6) act = ACT_POINT;
      else if (k < 9) act = ACT_RECT;
      else if (k < 10) act = ACT_THRESH;
      else if (k < 11) act = ACT_FLIP;
      else if (k < 12) act = ACT_ROTATE;
      else if (k < 19) act = ACT_READ;
      else act = ACT_UNUSED;
      if (act == ACT_NEW) begin
        if ($urandom_range(0, 9) == 0)
          send_item(act, 12'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom()),
                    16'($urandom()));
        else
          send_item(act, 12'($urandom()), 12'($urandom()), 12'($urandom_range(0, 10)),
                    12'($urandom_range(0, 10)), 16'($urandom()));
      end else begin
        send_item(act, pick_pos(sb.width), pick_pos(sb.height),
                  (($urandom_range(0, 4) == 0) ? 12'($urandom())
                                               : 12'($urandom_range(0, 8))),
                  (($urandom_range(0, 4) == 0) ? 12'($urandom())
                                               : 12'($urandom_range(0, 8))),
                  16'($urandom()));
      end
    end
    start_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== image_buffer_raster_ops.f =====
+incdir+sv
sv/ibro_pkg.sv
sv/ibro_mem.sv
sv/image_buffer_raster_ops.sv
tb/image_buffer_raster_ops_test.sv
